// ===== rtl/core/kse_pkg.sv =====
// ----------------------------------------------------------------------------
// kse_pkg
// Field widths, operation, direction and register codes, register reset
// values, and the item and result types of the spin-exchange lattice.
// ----------------------------------------------------------------------------
`default_nettype none

package kse_pkg;

    localparam int ROW_W      = 7;
    localparam int COL_W      = 7;
    localparam int DIR_W      = 2;
    localparam int PROB_BITS  = 16;
    localparam int OCC_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int WIN_ROWS   = 4;
    localparam int WIN_W      = 2;
    localparam int ROWX_W     = ROW_W + 1;
    localparam int RCMP_W     = ROW_W + 2;

    localparam logic OP_MOVE  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_DE4  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DE8  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DE12 = 2'd2;

    localparam logic [PROB_BITS-1:0] DE4_RESET  = 16'd1200;
    localparam logic [PROB_BITS-1:0] DE8_RESET  = 16'd22;
    localparam logic [PROB_BITS-1:0] DE12_RESET = 16'd0;

    typedef struct packed {
        logic                 operation;
        logic [ROW_W-1:0]     row;
        logic [COL_W-1:0]     column;
        logic [DIR_W-1:0]     direction;
        logic [PROB_BITS-1:0] random_value;
    } item_t;

    typedef struct packed {
        logic             accepted;
        logic [OCC_W-1:0] row_occupancy;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/kse_stream_if.sv =====
// ----------------------------------------------------------------------------
// kse_stream_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface kse_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/kawasaki_spin_exchange_lattice.sv =====
// Throughput: one item per cycle; a transfer is taken every cycle while results drain.
// Each item is held in the stage 1 register and its result in the output register.
// The lattice sits in four row-interleaved banks, each read once per item, so a
// four-row window around the site comes out of a single read of the banks.
// Reset: per-row valid bits clear at once; an unwritten row reads as its initial
// layout, so no clearing pass runs and items are taken right after reset.
// ----------------------------------------------------------------------------
// kawasaki_spin_exchange_lattice
// Conserved-spin Monte Carlo lattice: exchange moves with thresholded
// Metropolis acceptance and per-row occupancy queries.
// ----------------------------------------------------------------------------
`default_nettype none

module kawasaki_spin_exchange_lattice
    import kse_pkg::*;
#(
    parameter int LATTICE_SIZE = 128
) (
    input  wire                  clk,
    input  wire                  rst_n,
    kse_stream_if.sink           item,
    kse_stream_if.source         result,
    input  wire                  cfg_write_en,
    input  wire [CFG_IDX_W-1:0]  cfg_index,
    input  wire [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW         = $clog2(LATTICE_SIZE);
    localparam int CNT_W      = $clog2(LATTICE_SIZE + 1);
    localparam int BANK_ROWS  = (LATTICE_SIZE + 3) / 4;
    localparam int AW         = $clog2(BANK_ROWS);
    localparam int BANK_DEPTH = 2 ** AW;
    localparam int RNUM_W     = AW + 2;
    localparam int HALF       = LATTICE_SIZE / 2;
    localparam int COL_SPAN   = 2 ** COL_W;

    typedef struct packed {
        logic [CNT_W-1:0]        count;
        logic [LATTICE_SIZE-1:0] bits;
    } entry_t;

    function automatic entry_t reset_entry(input logic [RNUM_W-1:0] row_num);
        entry_t e;
        e.count = (row_num < RNUM_W'(HALF)) ? '0 : CNT_W'(LATTICE_SIZE);
        e.bits  = (row_num < RNUM_W'(HALF)) ? '0 : '1;
        return e;
    endfunction

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic out_valid_reg;
    logic s1_valid_reg;
    logic out_free;
    logic in_ready;
    logic item_fire;
    logic s1_fire;

    assign out_free   = !out_valid_reg || result.ready;
    assign in_ready   = !s1_valid_reg || out_free;
    assign item.ready = in_ready;
    assign item_fire  = item.valid && in_ready;
    assign s1_fire    = s1_valid_reg && in_ready;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [PROB_BITS-1:0] thr_de4_reg;
    logic [PROB_BITS-1:0] thr_de8_reg;
    logic [PROB_BITS-1:0] thr_de12_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_de4_reg  <= DE4_RESET;
            thr_de8_reg  <= DE8_RESET;
            thr_de12_reg <= DE12_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_DE4:  thr_de4_reg  <= cfg_data;
                CFG_DE8:  thr_de8_reg  <= cfg_data;
                CFG_DE12: thr_de12_reg <= cfg_data;
                default:  ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Column wrap table
    // ------------------------------------------------------------------
    logic [CW-1:0] col_tbl [COL_SPAN];

    for (genvar i = 0; i < COL_SPAN; i++)
    begin : g_col_tbl
        assign col_tbl[i] = CW'(i % LATTICE_SIZE);
    end

    // ------------------------------------------------------------------
    // Row banks: window base and read addresses
    // ------------------------------------------------------------------
    logic [ROWX_W-1:0] in_base;

    assign in_base = (item.payload.operation == OP_MOVE && item.payload.direction == DIR_UP)
                   ? ROWX_W'(item.payload.row) - ROWX_W'(2)
                   : ROWX_W'(item.payload.row) - ROWX_W'(1);

    logic [WIN_ROWS-1:0] wr_en;
    logic [AW-1:0]       wr_addr       [WIN_ROWS];
    entry_t              wr_data       [WIN_ROWS];
    entry_t              rd_data_reg   [WIN_ROWS];
    logic [AW-1:0]       rd_addr_reg   [WIN_ROWS];
    logic [WIN_ROWS-1:0] rd_valid_reg;
    logic [BANK_DEPTH-1:0] row_valid_reg [WIN_ROWS];
    logic [WIN_ROWS-1:0] byp_valid_reg;
    logic [AW-1:0]       byp_addr_reg  [WIN_ROWS];
    entry_t              byp_data_reg  [WIN_ROWS];
    entry_t              bank_entry    [WIN_ROWS];

    for (genvar b = 0; b < WIN_ROWS; b++)
    begin : g_bank
        logic [WIN_W-1:0]  rd_pos;
        logic [ROWX_W-1:0] rd_row;
        logic [AW-1:0]     rd_addr;
        entry_t            mem [BANK_DEPTH];

        assign rd_pos  = WIN_W'(b) - in_base[WIN_W-1:0];
        assign rd_row  = in_base + ROWX_W'(rd_pos);
        assign rd_addr = AW'(rd_row >> 2);

        always_ff @(posedge clk)
        begin
            if (wr_en[b])
            begin
                mem[wr_addr[b]] <= wr_data[b];
            end
            if (item_fire)
            begin
                rd_data_reg[b] <= mem[rd_addr];
                rd_addr_reg[b] <= rd_addr;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                row_valid_reg[b] <= '0;
                rd_valid_reg[b]  <= 1'b0;
                byp_valid_reg[b] <= 1'b0;
            end
            else
            begin
                if (item_fire)
                begin
                    rd_valid_reg[b] <= row_valid_reg[b][rd_addr];
                end
                if (wr_en[b])
                begin
                    row_valid_reg[b][wr_addr[b]] <= 1'b1;
                end
                if (in_ready)
                begin
                    byp_valid_reg[b] <= wr_en[b];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (wr_en[b])
            begin
                byp_addr_reg[b] <= wr_addr[b];
                byp_data_reg[b] <= wr_data[b];
            end
        end

        // take the write that landed on the read edge, else the stored row, or the reset layout for an unwritten row
        always_comb
        begin
            if (byp_valid_reg[b] && byp_addr_reg[b] == rd_addr_reg[b])
            begin
                bank_entry[b] = byp_data_reg[b];
            end
            else if (rd_valid_reg[b])
            begin
                bank_entry[b] = rd_data_reg[b];
            end
            else
            begin
                bank_entry[b] = reset_entry({rd_addr_reg[b], WIN_W'(b)});
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: item register and move evaluation
    // ------------------------------------------------------------------
    item_t s1_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            s1_item_reg <= item.payload;
        end
    end

    logic [ROWX_W-1:0]    s1_base;
    logic                 s1_up;
    logic                 s1_down;
    logic                 s1_vert;
    logic [WIN_W-1:0]     pos_r;
    logic [WIN_W-1:0]     pos_n;
    logic [CW-1:0]        col_c;
    logic [CW-1:0]        col_l;
    logic [CW-1:0]        col_r;
    logic [CW-1:0]        col_n;
    logic [RCMP_W-1:0]    r_ext;
    logic [RCMP_W-1:0]    nr_ext;
    entry_t               win     [WIN_ROWS];
    entry_t               new_win [WIN_ROWS];
    logic                 spin_a;
    logic                 spin_b;
    logic [2:0]           cnt_a;
    logic [2:0]           cnt_b;
    logic signed [3:0]    cnt_diff;
    logic signed [3:0]    de_quarter;
    logic [PROB_BITS-1:0] thr;
    logic                 row_ok;
    logic                 site_inner;
    logic                 nbr_inner;
    logic                 metro_ok;
    logic                 move_ok;
    logic [OCC_W-1:0]     occ;

    assign s1_up   = s1_item_reg.operation == OP_MOVE && s1_item_reg.direction == DIR_UP;
    assign s1_down = s1_item_reg.operation == OP_MOVE && s1_item_reg.direction == DIR_DOWN;
    assign s1_vert = s1_up || s1_down;
    assign s1_base = s1_up ? ROWX_W'(s1_item_reg.row) - ROWX_W'(2)
                           : ROWX_W'(s1_item_reg.row) - ROWX_W'(1);
    assign pos_r   = s1_up ? WIN_W'(2) : WIN_W'(1);
    assign pos_n   = s1_up ? WIN_W'(1) : (s1_down ? WIN_W'(2) : pos_r);

    assign col_c = col_tbl[s1_item_reg.column];
    assign col_l = (col_c == '0) ? CW'(LATTICE_SIZE - 1) : col_c - CW'(1);
    assign col_r = (col_c == CW'(LATTICE_SIZE - 1)) ? '0 : col_c + CW'(1);

    always_comb
    begin
        case (s1_item_reg.direction)
            DIR_LEFT:  col_n = col_l;
            DIR_RIGHT: col_n = col_r;
            default:   col_n = col_c;
        endcase
    end

    assign r_ext  = RCMP_W'(s1_item_reg.row);
    assign nr_ext = s1_up ? r_ext - RCMP_W'(1) : (s1_down ? r_ext + RCMP_W'(1) : r_ext);

    always_comb
    begin
        for (int j = 0; j < WIN_ROWS; j++)
        begin
            win[j] = bank_entry[s1_base[WIN_W-1:0] + WIN_W'(j)];
        end
    end

    assign spin_a = win[pos_r].bits[col_c];
    assign spin_b = win[pos_n].bits[col_n];

    assign cnt_a = 3'(win[pos_r - WIN_W'(1)].bits[col_c]) + 3'(win[pos_r + WIN_W'(1)].bits[col_c])
                 + 3'(win[pos_r].bits[col_l]) + 3'(win[pos_r].bits[col_r]);
    assign cnt_b = 3'(win[pos_n - WIN_W'(1)].bits[col_n]) + 3'(win[pos_n + WIN_W'(1)].bits[col_n])
                 + 3'(win[pos_n].bits[(col_n == '0) ? CW'(LATTICE_SIZE - 1) : col_n - CW'(1)])
                 + 3'(win[pos_n].bits[(col_n == CW'(LATTICE_SIZE - 1)) ? '0 : col_n + CW'(1)]);

    assign cnt_diff   = $signed({1'b0, cnt_a}) - $signed({1'b0, cnt_b});
    assign de_quarter = spin_a ? cnt_diff + 4'sd1 : 4'sd1 - cnt_diff;

    always_comb
    begin
        case (de_quarter)
            4'sd1:   thr = thr_de4_reg;
            4'sd2:   thr = thr_de8_reg;
            default: thr = thr_de12_reg;
        endcase
    end

    assign metro_ok   = (de_quarter <= 4'sd0) || (s1_item_reg.random_value < thr);
    assign row_ok     = r_ext < RCMP_W'(LATTICE_SIZE);
    assign site_inner = r_ext != '0 && r_ext < RCMP_W'(LATTICE_SIZE - 1);
    assign nbr_inner  = nr_ext != '0 && nr_ext < RCMP_W'(LATTICE_SIZE - 1);
    assign move_ok    = s1_item_reg.operation == OP_MOVE && row_ok && site_inner
                     && nbr_inner && (spin_a != spin_b) && metro_ok;
    assign occ        = (s1_item_reg.operation == OP_QUERY && row_ok) ? OCC_W'(win[1].count) : '0;

    // swap the two spins and move one count across rows on a vertical swap
    always_comb
    begin
        for (int j = 0; j < WIN_ROWS; j++)
        begin
            new_win[j] = win[j];
            if (WIN_W'(j) == pos_r)
            begin
                new_win[j].bits[col_c] = spin_b;
                if (s1_vert)
                begin
                    new_win[j].count = spin_a ? win[j].count - CNT_W'(1)
                                              : win[j].count + CNT_W'(1);
                end
            end
            if (WIN_W'(j) == pos_n)
            begin
                new_win[j].bits[col_n] = spin_a;
                if (s1_vert)
                begin
                    new_win[j].count = spin_a ? win[j].count + CNT_W'(1)
                                              : win[j].count - CNT_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        for (int b = 0; b < WIN_ROWS; b++)
        begin
            wr_en[b]   = s1_fire && move_ok
                      && ((WIN_W'(b) - s1_base[WIN_W-1:0]) == pos_r
                       || (WIN_W'(b) - s1_base[WIN_W-1:0]) == pos_n);
            wr_addr[b] = rd_addr_reg[b];
            wr_data[b] = new_win[WIN_W'(b) - s1_base[WIN_W-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    result_t out_payload_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_payload_reg.accepted      <= move_ok;
            out_payload_reg.row_occupancy <= occ;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_payload_reg;

`ifndef ASSERT_OFF
    a_two_rows_max: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(wr_en) <= 2)
        else $error("more than two lattice rows written by one move");

    a_query_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_item_reg.operation == OP_QUERY |-> wr_en == '0)
        else $error("occupancy query wrote the lattice");

    a_swap_writes: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && move_ok |-> wr_en != '0)
        else $error("accepted move left the lattice unchanged");

    a_move_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.payload.accepted |-> result.payload.row_occupancy == '0)
        else $error("accepted move carries an occupancy count");

    a_row_marked: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en[0] |=> row_valid_reg[0][$past(wr_addr[0])])
        else $error("written row not marked valid");
`endif

endmodule

`default_nettype wire
